// ===== hw/rtl/nearest_frame_timestamp_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-frame timestamp sampler
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_FRAME_TIMESTAMP_SAMPLER_ASSERT_SVH
`define NEAREST_FRAME_TIMESTAMP_SAMPLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define NFTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfts assertion failed");

// Next-cycle implication.
`define NFTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfts assertion failed");

`else

`define NFTS_ASSERT_IMPL(label, ante, cons)
`define NFTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/nfts_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest-frame timestamp sampler package
// Widths, payload types and result status codes shared by all modules.
// ----------------------------------------------------------------------------
package nfts_pkg;

    localparam int TIME_BITS    = 48;
    localparam int ORDINAL_BITS = 32;
    localparam int MAX_RUN      = 64;
    localparam int PERIOD_BITS  = 27;

    localparam int TPOS_BITS    = TIME_BITS - 1;
    localparam int RUN_BITS     = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(1000);

    typedef enum logic [2:0] {
        STATUS_SELECT    = 3'd0,
        STATUS_NEGATIVE  = 3'd1,
        STATUS_DECREASED = 3'd2,
        STATUS_OVERFLOW  = 3'd3,
        STATUS_TRUNCATED = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [TIME_BITS-1:0] frame_time;
        logic [ORDINAL_BITS-1:0]     frame_number;
    } frame_t;

    typedef struct packed {
        logic [TPOS_BITS-1:0]    target_index;
        logic [TPOS_BITS-1:0]    target_time;
        logic [ORDINAL_BITS-1:0] chosen_number;
        logic [TPOS_BITS-1:0]    chosen_time;
        status_t                 status;
        logic                    last;
    } result_t;

    // One classified frame waiting in the queue between front and back.
    typedef struct packed {
        logic                    negative;
        logic [TPOS_BITS-1:0]    time_val;
        logic [ORDINAL_BITS-1:0] number;
    } qitem_t;

endpackage

// ===== hw/rtl/nfts_front.sv =====
// ----------------------------------------------------------------------------
// Nearest-frame timestamp sampler front end
// Accepts frames, classifies the sign of the timestamp and queues them.
// ----------------------------------------------------------------------------
module nfts_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  nfts_pkg::frame_t in_data,
    output logic            q_valid,
    output nfts_pkg::qitem_t q_item,
    input  logic            q_pop
);

    nfts_pkg::qitem_t                  entry_reg [nfts_pkg::QUEUE_DEPTH];
    logic [nfts_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [nfts_pkg::QPTR_BITS-1:0]    wr_ptr_next;
    logic [nfts_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [nfts_pkg::QPTR_BITS-1:0]    rd_ptr_next;
    logic [nfts_pkg::QCNT_BITS-1:0]    count_reg;
    logic [nfts_pkg::QCNT_BITS-1:0]    count_next;
    logic                              push;
    nfts_pkg::qitem_t                  new_item;

    assign in_stall = (count_reg == nfts_pkg::QCNT_BITS'(nfts_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.negative = in_data.frame_time[nfts_pkg::TIME_BITS-1];
        new_item.time_val = in_data.frame_time[nfts_pkg::TPOS_BITS-1:0];
        new_item.number   = in_data.frame_number;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == nfts_pkg::QPTR_BITS'(nfts_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + nfts_pkg::QPTR_BITS'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == nfts_pkg::QPTR_BITS'(nfts_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + nfts_pkg::QPTR_BITS'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + nfts_pkg::QCNT_BITS'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - nfts_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== hw/rtl/nfts_back.sv =====
// ----------------------------------------------------------------------------
// Nearest-frame timestamp sampler back end
// Walks the crossed targets of one frame, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module nfts_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [nfts_pkg::PERIOD_BITS-1:0]    sample_period,
    input  logic                                q_valid,
    input  nfts_pkg::qitem_t                    q_item,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output nfts_pkg::result_t                   out_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                                state_reg;
    state_t                                state_next;

    logic                                  have_prev_reg;
    logic                                  have_prev_next;
    logic [nfts_pkg::TPOS_BITS-1:0]        prev_time_reg;
    logic [nfts_pkg::TPOS_BITS-1:0]        prev_time_next;
    logic [nfts_pkg::ORDINAL_BITS-1:0]     prev_num_reg;
    logic [nfts_pkg::ORDINAL_BITS-1:0]     prev_num_next;
    logic [nfts_pkg::TPOS_BITS-1:0]        next_target_reg;
    logic [nfts_pkg::TPOS_BITS-1:0]        next_target_next;
    logic [nfts_pkg::TPOS_BITS-1:0]        counter_reg;
    logic [nfts_pkg::TPOS_BITS-1:0]        counter_next;
    logic [nfts_pkg::RUN_BITS-1:0]         run_reg;
    logic [nfts_pkg::RUN_BITS-1:0]         run_next;

    // Current frame, loaded when it leaves the queue.
    nfts_pkg::qitem_t                      item_reg;
    nfts_pkg::qitem_t                      item_next;
    logic [nfts_pkg::TIME_BITS-1:0]        tp_sum_reg;
    logic [nfts_pkg::TIME_BITS-1:0]        tp_sum_next;

    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    nfts_pkg::result_t                     out_data_reg;
    nfts_pkg::result_t                     out_data_next;

    logic [nfts_pkg::PERIOD_BITS-1:0]      period_eff;
    logic [nfts_pkg::TIME_BITS-1:0]        step_sum;
    logic                                  can_emit;
    logic                                  emit;
    nfts_pkg::result_t                     result;
    logic                                  t_lt_next;
    logic                                  t_lt_sum;
    logic                                  decreased;
    logic                                  pick_prev;
    logic                                  at_end;
    logic                                  store_frame;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        period_eff = (sample_period == '0) ? nfts_pkg::PERIOD_BITS'(1) : sample_period;
        step_sum   = {1'b0, next_target_reg} + nfts_pkg::TIME_BITS'(period_eff);
        can_emit   = !out_valid_reg || !out_stall;
        t_lt_next  = item_reg.time_val < next_target_reg;
        t_lt_sum   = {1'b0, item_reg.time_val} < step_sum;
        decreased  = have_prev_reg && (item_reg.time_val < prev_time_reg);
        at_end     = (run_reg == nfts_pkg::RUN_BITS'(nfts_pkg::MAX_RUN - 1));
        // The previous frame is never later than the current one, so it wins
        // when it sits at or past the target, or when the target lies at or
        // before the midpoint of the two frames.
        pick_prev  = have_prev_reg &&
                     ((prev_time_reg >= next_target_reg) ||
                      ({next_target_reg, 1'b0} <= tp_sum_reg));
    end

    always_comb
    begin
        state_next       = state_reg;
        have_prev_next   = have_prev_reg;
        prev_time_next   = prev_time_reg;
        prev_num_next    = prev_num_reg;
        next_target_next = next_target_reg;
        counter_next     = counter_reg;
        run_next         = run_reg;
        item_next        = item_reg;
        tp_sum_next      = tp_sum_reg;
        q_pop            = 1'b0;
        emit             = 1'b0;
        store_frame      = 1'b0;
        result           = '0;
        result.status    = nfts_pkg::STATUS_SELECT;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    item_next   = q_item;
                    tp_sum_next = {1'b0, q_item.time_val} + {1'b0, prev_time_reg};
                    run_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (can_emit)
                begin
                    priority if (item_reg.negative)
                    begin
                        emit          = 1'b1;
                        result.status = nfts_pkg::STATUS_NEGATIVE;
                        result.last   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (decreased)
                    begin
                        emit          = 1'b1;
                        result.status = nfts_pkg::STATUS_DECREASED;
                        result.last   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (t_lt_next)
                    begin
                        // No target reached by this frame: nothing to send.
                        store_frame = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (step_sum[nfts_pkg::TPOS_BITS])
                    begin
                        emit          = 1'b1;
                        result.status = nfts_pkg::STATUS_OVERFLOW;
                        result.last   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        emit                 = 1'b1;
                        result.target_index  = counter_reg;
                        result.target_time   = next_target_reg;
                        result.chosen_number = pick_prev ? prev_num_reg : item_reg.number;
                        result.chosen_time   = pick_prev ? prev_time_reg : item_reg.time_val;
                        result.status        = (at_end && !t_lt_sum)
                                             ? nfts_pkg::STATUS_TRUNCATED
                                             : nfts_pkg::STATUS_SELECT;
                        result.last          = at_end || t_lt_sum;
                        next_target_next     = step_sum[nfts_pkg::TPOS_BITS-1:0];
                        counter_next         = counter_reg + nfts_pkg::TPOS_BITS'(1);
                        run_next             = run_reg + nfts_pkg::RUN_BITS'(1);
                        if (at_end || t_lt_sum)
                        begin
                            store_frame = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (store_frame)
        begin
            have_prev_next = 1'b1;
            prev_time_next = item_reg.time_val;
            prev_num_next  = item_reg.number;
        end

        out_valid_next = can_emit ? emit : out_valid_reg;
        out_data_next  = (can_emit && emit) ? result : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            have_prev_reg   <= 1'b0;
            prev_time_reg   <= '0;
            prev_num_reg    <= '0;
            next_target_reg <= '0;
            counter_reg     <= '0;
            run_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            have_prev_reg   <= have_prev_next;
            prev_time_reg   <= prev_time_next;
            prev_num_reg    <= prev_num_next;
            next_target_reg <= next_target_next;
            counter_reg     <= counter_next;
            run_reg         <= run_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        tp_sum_reg   <= tp_sum_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hw/rtl/nearest_frame_timestamp_sampler.sv =====
// ----------------------------------------------------------------------------
// Nearest-frame timestamp sampler
// Resamples a stream of decoded frames onto a regular grid of target times.
// ----------------------------------------------------------------------------
// Usage:
// Frames enter on in_valid/in_stall/in_data; results leave on
// out_valid/out_stall/out_data. A transaction completes when valid is high
// and stall is low. Each frame yields zero or more results, the final one
// marked by last. A negative or decreasing time gives one error result, and
// a target overflow ends the frame's results with one error result.
// A frame waits in a two-entry queue, is loaded by the back end from its idle
// state and then produces one result per cycle while the output is not stalled.
// The back end's target loop, one target per cycle, sets this rate.
// On an idle block out_valid rises after the frame has passed the queue, the
// back end's load from idle and its output register.
// sample_period is written through cfg_wr_en/cfg_wr_data; the user must write it only while no
// frame is in flight, and the block itself does not enforce this. It resets to 1000; zero acts as one.
// Reset clears the queue, the stored frame and the target counter.
// A stalled result holds in the output register; the queue keeps taking
// frames until it is full, then in_stall rises.
// ----------------------------------------------------------------------------
`include "nearest_frame_timestamp_sampler_assert.svh"

module nearest_frame_timestamp_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  nfts_pkg::frame_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output nfts_pkg::result_t                 out_data,
    input  logic                              cfg_wr_en,
    input  logic [nfts_pkg::PERIOD_BITS-1:0]  cfg_wr_data
);

    logic [nfts_pkg::PERIOD_BITS-1:0] period_reg;
    logic                             q_valid;
    logic                             q_pop;
    nfts_pkg::qitem_t                 q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= nfts_pkg::PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= cfg_wr_data;
        end
    end

    nfts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    nfts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_period (period_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

    // The back end only takes a frame that is there, and never twice in a row.
    `NFTS_ASSERT_IMPL(a_pop_needs_item, q_pop, q_valid)
    `NFTS_ASSERT_NEXT(a_pop_spaced, q_pop, !q_pop)
    // A full queue always has a frame to hand over.
    `NFTS_ASSERT_IMPL(a_full_not_empty, in_stall, q_valid)
    // Any result other than a plain selection ends the frame's run.
    `NFTS_ASSERT_IMPL(a_error_is_last, out_valid && (out_data.status != nfts_pkg::STATUS_SELECT), out_data.last)

endmodule

// ===== tb/tb_nearest_frame_timestamp_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the nearest-frame timestamp sampler
// Drives frames through the valid/stall input channel and predicts every
// result with a behavioral copy of the target loop. Each received result is
// compared field by field with the oldest prediction. Directed tests cover
// the reset period, first frame, ties, rejected times, period extremes, run
// truncation and the top of the time range; random traffic runs under four
// idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_nearest_frame_timestamp_sampler;

    localparam logic [63:0] TIME_TOP = (64'd1 << nfts_pkg::TPOS_BITS) - 64'd1;
    localparam logic [nfts_pkg::PERIOD_BITS-1:0] PERIOD_MAX = '1;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 40;
    localparam int RANDOM_FRAMES = 22;
    localparam int TOP_FRAMES    = 3;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    nfts_pkg::frame_t                 in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    nfts_pkg::result_t                out_data;
    logic                             cfg_wr_en = 1'b0;
    logic [nfts_pkg::PERIOD_BITS-1:0] cfg_wr_data = '0;

    // Shadow of the block's register and frame/target state.
    logic [nfts_pkg::PERIOD_BITS-1:0]  period_reg = nfts_pkg::PERIOD_RESET;
    bit                                have_prev = 1'b0;
    logic [nfts_pkg::TPOS_BITS-1:0]    prev_time = '0;
    logic [nfts_pkg::ORDINAL_BITS-1:0] prev_num = '0;
    logic [nfts_pkg::TPOS_BITS-1:0]    next_tgt = '0;
    logic [nfts_pkg::TPOS_BITS-1:0]    tgt_count = '0;

    nfts_pkg::result_t pending_results[$];
    int unsigned       sender_gap_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       fail_count = 0;
    int unsigned       frames_sent = 0;
    int unsigned       results_seen = 0;
    int unsigned       truncated_runs = 0;
    int unsigned       overflow_count = 0;
    int unsigned       negative_count = 0;
    int unsigned       decreased_count = 0;

    nearest_frame_timestamp_sampler u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [63:0] abs_diff(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic nfts_pkg::result_t error_result(nfts_pkg::status_t code);
        nfts_pkg::result_t r;
        r = '0;
        r.status = code;
        return r;
    endfunction

    // Works out the results of one accepted frame and updates the shadow state.
    function automatic void predict_frame(nfts_pkg::frame_t f);
        logic [nfts_pkg::TPOS_BITS-1:0] t;
        logic [63:0]                    spacing;
        nfts_pkg::result_t              run_q[$];
        nfts_pkg::result_t              r;
        bit                             hit_top;
        t = f.frame_time[nfts_pkg::TPOS_BITS-1:0];
        spacing = (period_reg == '0) ? 64'd1 : 64'(period_reg);
        hit_top = 1'b0;
        if (f.frame_time[nfts_pkg::TIME_BITS-1])
        begin
            run_q = {run_q, error_result(nfts_pkg::STATUS_NEGATIVE)};
            negative_count++;
        end
        else if (have_prev && t < prev_time)
        begin
            run_q = {run_q, error_result(nfts_pkg::STATUS_DECREASED)};
            decreased_count++;
        end
        else
        begin
            while (run_q.size() < nfts_pkg::MAX_RUN && t >= next_tgt)
            begin
                if (64'(next_tgt) + spacing > TIME_TOP)
                begin
                    run_q = {run_q, error_result(nfts_pkg::STATUS_OVERFLOW)};
                    overflow_count++;
                    hit_top = 1'b1;
                    break;
                end
                r = '0;
                r.target_index = tgt_count;
                r.target_time  = next_tgt;
                // On equal distance the earlier, stored frame wins.
                if (have_prev && abs_diff(64'(next_tgt), 64'(prev_time))
                        <= abs_diff(64'(t), 64'(next_tgt)))
                begin
                    r.chosen_number = prev_num;
                    r.chosen_time   = prev_time;
                end
                else
                begin
                    r.chosen_number = f.frame_number;
                    r.chosen_time   = t;
                end
                if (run_q.size() == nfts_pkg::MAX_RUN - 1
                        && 64'(t) >= 64'(next_tgt) + spacing)
                begin
                    r.status = nfts_pkg::STATUS_TRUNCATED;
                    truncated_runs++;
                end
                else
                begin
                    r.status = nfts_pkg::STATUS_SELECT;
                end
                run_q = {run_q, r};
                next_tgt  = next_tgt + nfts_pkg::TPOS_BITS'(spacing);
                tgt_count = tgt_count + 1'b1;
            end
            if (!hit_top)
            begin
                have_prev = 1'b1;
                prev_time = t;
                prev_num  = f.frame_number;
            end
        end
        foreach (run_q[i])
        begin
            r = run_q[i];
            r.last = (i == run_q.size() - 1);
            pending_results = {pending_results, r};
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        nfts_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("target_index", 64'(want.target_index), 64'(out_data.target_index));
                check_field("target_time", 64'(want.target_time), 64'(out_data.target_time));
                check_field("chosen_number", 64'(want.chosen_number),
                            64'(out_data.chosen_number));
                check_field("chosen_time", 64'(want.chosen_time), 64'(out_data.chosen_time));
                check_field("status", 64'(want.status), 64'(out_data.status));
                check_field("last", 64'(want.last), 64'(out_data.last));
            end
        end
    end

    task automatic send_frame(nfts_pkg::frame_t f);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        do
            @(posedge clk);
        while (in_stall);
        frames_sent++;
        predict_frame(f);
    endtask

    task automatic send_raw(logic [nfts_pkg::TIME_BITS-1:0] raw,
                            logic [nfts_pkg::ORDINAL_BITS-1:0] num);
        nfts_pkg::frame_t f;
        f.frame_time   = raw;
        f.frame_number = num;
        send_frame(f);
    endtask

    // Frames that cause no result may still be in the block after the last
    // result, so the task also waits out SETTLE_CYCLES before the block counts as idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(logic [nfts_pkg::PERIOD_BITS-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        period_reg = value;
    endtask

    task automatic set_idling(int unsigned gap_pct, int unsigned hold_pct);
        sender_gap_pct = gap_pct;
        stall_pct      = hold_pct;
    endtask

    task automatic send_random_frame();
        nfts_pkg::frame_t f;
        logic [63:0]      spacing;
        logic [63:0]      t;
        logic [63:0]      low;
        int unsigned      pick;
        bit               neg;
        spacing = (period_reg == '0) ? 64'd1 : 64'(period_reg);
        pick = $urandom_range(99);
        neg = 1'b0;
        t = 64'(prev_time);
        if (pick < 8)
        begin
            neg = 1'b1;
        end
        else if (pick < 14 && have_prev && prev_time != '0)
        begin
            t = 64'(prev_time) - 64'd1 - ({$urandom, $urandom} % 64'(prev_time));
        end
        else if (pick < 18)
        begin
            // Far jump: many targets at once, usually a truncated run.
            t = 64'(next_tgt) + spacing * $urandom_range(90, 60);
        end
        else if (pick < 26 && have_prev)
        begin
            t = 64'(prev_time);
        end
        else
        begin
            low = (64'(next_tgt) > spacing) ? 64'(next_tgt) - spacing : 64'd0;
            t = low + $urandom_range(32'(2 * spacing));
            if (have_prev && t < 64'(prev_time))
                t = 64'(prev_time);
        end
        f.frame_number = $urandom;
        f.frame_time = neg ? {1'b1, 47'({$urandom, $urandom})}
                           : {1'b0, t[nfts_pkg::TPOS_BITS-1:0]};
        send_frame(f);
    endtask

    task automatic test_first_frame_and_ties();
        set_idling(0, 0);
        send_raw(48'd0, 32'd0);
        send_raw(48'd500, 32'd1);
        send_raw(48'd1500, 32'd2);
        send_raw(48'd1700, 32'hFFFF_FFFF);
        send_raw(48'd2300, 32'd4);
        send_raw(48'd2999, 32'd5);
        send_raw(48'd3000, 32'd6);
        send_raw(48'd3000, 32'd7);
    endtask

    task automatic test_rejected_times();
        send_raw(48'hFFFF_FFFF_FFFF, 32'd8);
        send_raw(48'h8000_0000_0000, 32'hFFFF_FFFF);
        send_raw(nfts_pkg::TIME_BITS'(prev_time - 1'b1), 32'd9);
        send_raw(nfts_pkg::TIME_BITS'(64'(prev_time) + 64'd1), 32'd10);
    endtask

    task automatic test_period_extremes();
        write_period('0);
        send_raw(nfts_pkg::TIME_BITS'(64'(next_tgt) + 64'd4), 32'd11);
        write_period(nfts_pkg::PERIOD_BITS'(1));
        send_raw(nfts_pkg::TIME_BITS'(64'(next_tgt) + 64'd2), 32'd12);
        write_period(PERIOD_MAX);
        send_raw(nfts_pkg::TIME_BITS'(64'(next_tgt) + 64'(PERIOD_MAX)), 32'd13);
        send_raw(nfts_pkg::TIME_BITS'(64'(next_tgt) - 64'd1), 32'd14);
    endtask

    task automatic test_run_truncation();
        logic [63:0] far_time;
        write_period(nfts_pkg::PERIOD_BITS'(1));
        far_time = 64'(next_tgt) + 64'd100;
        send_raw(nfts_pkg::TIME_BITS'(far_time), 32'd15);
        send_raw(nfts_pkg::TIME_BITS'(far_time), 32'd16);
        send_raw(nfts_pkg::TIME_BITS'(far_time + 64'd1), 32'd17);
    endtask

    task automatic test_random_traffic(logic [nfts_pkg::PERIOD_BITS-1:0] period_val,
                                       int unsigned gap_pct, int unsigned hold_pct);
        write_period(period_val);
        set_idling(gap_pct, hold_pct);
        repeat (RANDOM_FRAMES) send_random_frame();
        wait_idle();
    endtask

    // Frames at the largest time with the largest period reach far more
    // targets than one run holds, so each of them ends in a truncated run.
    task automatic test_top_of_range();
        set_idling(0, 0);
        write_period(PERIOD_MAX);
        repeat (TOP_FRAMES) send_raw(nfts_pkg::TIME_BITS'(TIME_TOP), $urandom);
        send_raw(48'h8000_0000_0001, 32'd0);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_frame_and_ties();
        test_rejected_times();
        test_period_extremes();
        test_run_truncation();
        test_random_traffic(nfts_pkg::PERIOD_BITS'($urandom_range(40, 1)), 0, 0);
        test_random_traffic(nfts_pkg::PERIOD_BITS'($urandom), 76, 0);
        test_random_traffic(nfts_pkg::PERIOD_BITS'($urandom_range(5000, 100)), 0, 76);
        test_random_traffic(nfts_pkg::PERIOD_RESET, 13, 13);
        test_top_of_range();
        wait_idle();
        $display("Run covered %0d frames and %0d results, %0d truncated runs, %0d overflows.",
                 frames_sent, results_seen, truncated_runs, overflow_count);
        $display("Rejected frames: %0d with negative time, %0d with decreasing time.",
                 negative_count, decreased_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/nfts_pkg.sv
hw/rtl/nfts_front.sv
hw/rtl/nfts_back.sv
hw/rtl/nearest_frame_timestamp_sampler.sv
tb/tb_nearest_frame_timestamp_sampler.sv
